/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* rtl/tccs_pkg.sv */
// ----------------------------------------------------------------------------
// tccs_pkg
// Types and constants shared by the change score block.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

   localparam int JOB_IDX_W  = 8;
   localparam int JOB_SLOT_W = 6;

   localparam int COEF_R     = 77;
   localparam int COEF_G     = 151;
   localparam int COEF_B     = 28;
   localparam int GRAY_ROUND = 128;

   localparam int SCORE_ONE  = 65536;
   localparam int FRAC_STEPS = 18;

   typedef enum logic [2:0] {
      REG_WINDOW_LEN   = 3'd0,
      REG_SMALL_WIDTH  = 3'd1,
      REG_SMALL_HEIGHT = 3'd2,
      REG_FRAME_WIDTH  = 3'd3,
      REG_FRAME_HEIGHT = 3'd4,
      REG_COLOR_MODE   = 3'd5,
      REG_FRAME_LIMIT  = 3'd6,
      REG_LIMIT_ENABLE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                  sample;
      logic                  frame_end;
      logic                  score_en;
      logic [7:0]            gray;
      logic [JOB_IDX_W-1:0]  row;
      logic [JOB_IDX_W-1:0]  col;
      logic [JOB_SLOT_W-1:0] slot;
   } job_type;

endpackage

`default_nettype wire

/* rtl/tccs_front.sv */
// ----------------------------------------------------------------------------
// tccs_front
// Takes pixels, converts to gray in color mode, tracks raster position and sample grid.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_front import tccs_pkg::*; #(
   parameter int MAX_WINDOW    = 16,
   parameter int MAX_SMALL_DIM = 64,
   parameter int MAX_FRAME_DIM = 4096,
   localparam int LW  = $clog2(MAX_WINDOW + 1),
   localparam int SCW = $clog2(MAX_SMALL_DIM + 1),
   localparam int FCW = $clog2(MAX_FRAME_DIM + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           restart,
   input  wire logic [LW-1:0]  win_len,
   input  wire logic [FCW-1:0] frm_w,
   input  wire logic [FCW-1:0] frm_h,
   input  wire logic [SCW-1:0] sml_w,
   input  wire logic [SCW-1:0] sml_h,
   input  wire logic           color_mode,
   input  wire logic [31:0]    frame_limit,
   input  wire logic           limit_enable,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [23:0]    req_tdata,
   output logic                job_push,
   output job_type             job,
   input  wire logic           job_full
);

   localparam int FIW = (MAX_FRAME_DIM > 1) ? $clog2(MAX_FRAME_DIM) : 1;
   localparam int SLW = $clog2(MAX_WINDOW);
   localparam int PW  = $clog2(MAX_FRAME_DIM * MAX_SMALL_DIM + 1) + 1;

   logic [FIW-1:0] row_ff, row_in, col_ff, col_in;
   logic [SCW-1:0] m_ff, m_in, n_ff, n_in;
   logic [PW-1:0]  rsh_ff, rsh_in, mfh_ff, mfh_in, csw_ff, csw_in, nfw_ff, nfw_in;
   logic [31:0]    seen_ff, seen_in;
   logic [SLW-1:0] head_ff, head_in;

   logic        accept, limited, row_hit, col_hit, sample, row_last, frm_last, score_en;
   logic [15:0] gray_sum;
   logic [7:0]  gray;

   assign req_tready = !job_full;
   assign accept     = req_tvalid && req_tready;
   assign limited    = limit_enable && (seen_ff >= frame_limit);

   assign gray_sum = 16'(COEF_R * req_tdata[7:0] + COEF_G * req_tdata[15:8]
                         + COEF_B * req_tdata[23:16] + GRAY_ROUND);
   assign gray     = color_mode ? gray_sum[15:8] : req_tdata[7:0];

   assign row_hit  = (m_ff < sml_h) && (rsh_ff <= mfh_ff)
                     && (mfh_ff < rsh_ff + PW'(sml_h));
   assign col_hit  = (n_ff < sml_w) && (csw_ff <= nfw_ff)
                     && (nfw_ff < csw_ff + PW'(sml_w));
   assign sample   = row_hit && col_hit;
   assign row_last = (FCW'(col_ff) + FCW'(1)) >= frm_w;
   assign frm_last = row_last && ((FCW'(row_ff) + FCW'(1)) >= frm_h);
   assign score_en = seen_ff >= (32'(win_len) - 32'd1);

   assign job_push      = accept && !limited && (sample || frm_last);
   assign job.sample    = sample;
   assign job.frame_end = frm_last;
   assign job.score_en  = score_en;
   assign job.gray      = gray;
   assign job.row       = JOB_IDX_W'(m_ff);
   assign job.col       = JOB_IDX_W'(n_ff);
   assign job.slot      = JOB_SLOT_W'(head_ff);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      m_in    = m_ff;
      n_in    = n_ff;
      rsh_in  = rsh_ff;
      mfh_in  = mfh_ff;
      csw_in  = csw_ff;
      nfw_in  = nfw_ff;
      seen_in = seen_ff;
      head_in = head_ff;
      if (accept && !limited) begin
         if (sample) begin
            n_in   = n_ff + SCW'(1);
            nfw_in = nfw_ff + PW'(frm_w);
         end
         if (!row_last) begin
            col_in = col_ff + FIW'(1);
            csw_in = csw_ff + PW'(sml_w);
         end else begin
            col_in = '0;
            csw_in = '0;
            n_in   = '0;
            nfw_in = '0;
            if (row_hit) begin
               m_in   = m_ff + SCW'(1);
               mfh_in = mfh_ff + PW'(frm_h);
            end
            if (!frm_last) begin
               row_in = row_ff + FIW'(1);
               rsh_in = rsh_ff + PW'(sml_h);
            end else begin
               row_in = '0;
               rsh_in = '0;
               m_in   = '0;
               mfh_in = '0;
               if (seen_ff != '1) seen_in = seen_ff + 32'd1;
               if (LW'(head_ff) + LW'(1) >= win_len) head_in = '0;
               else head_in = head_ff + SLW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff  <= '0;
         col_ff  <= '0;
         m_ff    <= '0;
         n_ff    <= '0;
         rsh_ff  <= '0;
         mfh_ff  <= '0;
         csw_ff  <= '0;
         nfw_ff  <= '0;
         seen_ff <= '0;
         head_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         m_ff    <= m_in;
         n_ff    <= n_in;
         rsh_ff  <= rsh_in;
         mfh_ff  <= mfh_in;
         csw_ff  <= csw_in;
         nfw_ff  <= nfw_in;
         seen_ff <= seen_in;
         head_ff <= head_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tccs_fifo.sv */
// ----------------------------------------------------------------------------
// tccs_fifo
// Short job queue between the pixel front end and the score engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_fifo import tccs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type job_in,
   output logic         full,
   input  wire logic    pop,
   output job_type      job_out,
   output logic         valid
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   job_type       store_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic          do_push, do_pop;

   assign full    = cnt_ff == (AW + 1)'(DEPTH);
   assign valid   = cnt_ff != '0;
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign job_out = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ff] <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + AW'(1);
         if (do_pop) rd_ff <= rd_ff + AW'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + (AW + 1)'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - (AW + 1)'(1);
      end
   end

endmodule

`default_nettype wire

/* rtl/tccs_back.sv */
// ----------------------------------------------------------------------------
// tccs_back
// Sample ring, per-sample squared correlation and frame mean.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_back import tccs_pkg::*; #(
   parameter int MAX_WINDOW    = 16,
   parameter int MAX_SMALL_DIM = 64,
   localparam int LW  = $clog2(MAX_WINDOW + 1),
   localparam int SCW = $clog2(MAX_SMALL_DIM + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             restart,
   input  wire logic [LW-1:0]    win_len,
   input  wire logic [2*SCW-1:0] cnt,
   input  wire logic             job_valid,
   output logic                  job_pop,
   input  wire job_type          job,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [16:0]           rsp_score
);

   localparam int SLW = $clog2(MAX_WINDOW);
   localparam int SIW = (MAX_SMALL_DIM > 1) ? $clog2(MAX_SMALL_DIM) : 1;
   localparam int AW  = SLW + 2 * SIW;
   localparam int RD  = 1 << AW;
   localparam int VW  = 3 * LW + 10;
   localparam int RMW = 2 * VW + 1;
   localparam int SSW = 17 + 2 * SCW;
   localparam int NW  = SSW + 1;
   localparam int STW = $clog2(NW + FRAC_STEPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WR, ST_RA, ST_RB, ST_VAR, ST_CHK, ST_MUL, ST_DIV,
      ST_SFIN, ST_FEND, ST_MLOAD, ST_MOUT
   } state_type;

   state_type      state_ff;
   job_type        job_ff;
   logic [7:0]     ring_mem [RD];
   logic [7:0]     rd_data_ff;
   logic [SLW-1:0] slot_ff;
   logic [LW-1:0]  j_ff;
   logic [2*LW-1:0]   sx_ff;
   logic [3*LW-1:0]   sxx_ff;
   logic [8+LW-1:0]   sy_ff;
   logic [16+LW-1:0]  syy_ff;
   logic [8+2*LW-1:0] sxy_ff;
   logic signed [VW-1:0] vx_ff, vy_ff, cov_ff;
   logic [RMW-1:0] rem_ff, den_ff;
   logic [NW-1:0]  dvd_ff;
   logic [17:0]    q_ff;
   logic [STW-1:0] step_ff;
   logic           first_ff, mean_ff;
   logic [SSW-1:0] ssum_ff;
   logic           rsp_valid_ff;
   logic [16:0]    rsp_score_ff;

   logic [AW-1:0]  wr_addr, rd_addr;
   logic [RMW-1:0] cand;
   logic           ge;
   logic [VW-1:0]  acov;
   logic [18:0]    q_round;
   logic [16:0]    s_score;
   logic signed [VW-1:0] vx_c, vy_c, cov_c;

   assign job_pop    = (state_ff == ST_IDLE) && job_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_score  = rsp_score_ff;

   assign wr_addr = {job_ff.slot[SLW-1:0], job_ff.row[SIW-1:0], job_ff.col[SIW-1:0]};
   assign rd_addr = {slot_ff, job_ff.row[SIW-1:0], job_ff.col[SIW-1:0]};

   always_ff @(posedge clock) begin
      if (state_ff == ST_WR) ring_mem[wr_addr] <= job_ff.gray;
      rd_data_ff <= ring_mem[rd_addr];
   end

   assign vx_c  = $signed(VW'(win_len * sxx_ff)) - $signed(VW'(sx_ff * sx_ff));
   assign vy_c  = $signed(VW'(win_len * syy_ff)) - $signed(VW'(sy_ff * sy_ff));
   assign cov_c = $signed(VW'(win_len * sxy_ff)) - $signed(VW'(sx_ff * sy_ff));
   assign acov  = cov_ff[VW-1] ? VW'(-cov_ff) : VW'(cov_ff);

   assign cand    = first_ff ? rem_ff : {rem_ff[RMW-2:0], dvd_ff[NW-1]};
   assign ge      = cand >= den_ff;
   assign q_round = (19'(q_ff) + 19'd1) >> 1;
   assign s_score = (q_round > 19'(SCORE_ONE)) ? 17'(SCORE_ONE) : q_round[16:0];

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= ST_IDLE;
         ssum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_MOUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  if (job.sample) state_ff <= ST_WR;
                  else state_ff <= ST_FEND;
               end
            end
            ST_WR: begin
               sx_ff  <= '0;
               sxx_ff <= '0;
               sy_ff  <= '0;
               syy_ff <= '0;
               sxy_ff <= '0;
               j_ff   <= '0;
               if (LW'(job_ff.slot) + LW'(1) >= win_len) slot_ff <= '0;
               else slot_ff <= SLW'(job_ff.slot) + SLW'(1);
               if (job_ff.score_en) state_ff <= ST_RA;
               else state_ff <= ST_FEND;
            end
            ST_RA: state_ff <= ST_RB;
            ST_RB: begin
               sx_ff  <= sx_ff + (2 * LW)'(j_ff);
               sxx_ff <= sxx_ff + (3 * LW)'(j_ff * j_ff);
               sy_ff  <= sy_ff + (8 + LW)'(rd_data_ff);
               syy_ff <= syy_ff + (16 + LW)'(rd_data_ff * rd_data_ff);
               sxy_ff <= sxy_ff + (8 + 2 * LW)'(j_ff * rd_data_ff);
               j_ff   <= j_ff + LW'(1);
               if (LW'(slot_ff) + LW'(1) >= win_len) slot_ff <= '0;
               else slot_ff <= slot_ff + SLW'(1);
               if (j_ff + LW'(1) >= win_len) state_ff <= ST_VAR;
               else state_ff <= ST_RA;
            end
            ST_VAR: begin
               vx_ff    <= vx_c;
               vy_ff    <= vy_c;
               cov_ff   <= cov_c;
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               if (vx_ff <= 0 || vy_ff <= 0) begin
                  q_ff     <= '0;
                  state_ff <= ST_SFIN;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               rem_ff   <= RMW'(acov * acov);
               den_ff   <= RMW'($unsigned(vx_ff) * $unsigned(vy_ff));
               dvd_ff   <= '0;
               q_ff     <= '0;
               first_ff <= 1'b1;
               mean_ff  <= 1'b0;
               step_ff  <= STW'(FRAC_STEPS);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= ge ? cand - den_ff : cand;
               q_ff     <= {q_ff[16:0], ge};
               dvd_ff   <= dvd_ff << 1;
               first_ff <= 1'b0;
               step_ff  <= step_ff - STW'(1);
               if (step_ff == STW'(1)) state_ff <= mean_ff ? ST_MOUT : ST_SFIN;
            end
            ST_SFIN: begin
               // q = 0 here also stands for a flat sample
               ssum_ff  <= ssum_ff + SSW'(s_score);
               state_ff <= ST_FEND;
            end
            ST_FEND: begin
               if (job_ff.frame_end && job_ff.score_en) begin
                  state_ff <= ST_MLOAD;
               end else begin
                  if (job_ff.frame_end) ssum_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_MLOAD: begin
               rem_ff   <= '0;
               den_ff   <= RMW'(cnt);
               dvd_ff   <= NW'(ssum_ff) + NW'(cnt >> 1);
               q_ff     <= '0;
               first_ff <= 1'b0;
               mean_ff  <= 1'b1;
               step_ff  <= STW'(NW);
               state_ff <= ST_DIV;
            end
            ST_MOUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_score_ff <= q_ff[16:0];
                  ssum_ff      <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/temporal_correlation_change_score.sv */
// ----------------------------------------------------------------------------
// temporal_correlation_change_score
// Mean squared age/intensity correlation over a downsampled frame window.
//
// Channel  Dir  Payload
// req      in   tdata: chan_a, chan_b, chan_c (8b each)
// rsp      out  tdata: change_score (17b, Q16)
// csr      in   index 0..7, 32b write data
//
// Pixels are taken one a cycle while the job queue has room.
// A sampled pixel is scored by the engine once the window is full and only
// written to the ring before; a frame end adds a mean, computed by the
// bit-serial divider. Non-sampled pixels are free.
// Synchronous reset; any register write restarts the stream.
// Result register lets the engine finish while rsp is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module temporal_correlation_change_score import tccs_pkg::*; #(
   parameter int MAX_WINDOW    = 16,
   parameter int MAX_SMALL_DIM = 64,
   parameter int MAX_FRAME_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // chan_a[7:0], chan_b[15:8], chan_c[23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // change_score[16:0], zero fill
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int LW  = $clog2(MAX_WINDOW + 1);
   localparam int SCW = $clog2(MAX_SMALL_DIM + 1);
   localparam int FCW = $clog2(MAX_FRAME_DIM + 1);

   logic [4:0]  window_len_ff;
   logic [6:0]  small_width_ff, small_height_ff;
   logic [12:0] frame_width_ff, frame_height_ff;
   logic        color_mode_ff, limit_enable_ff;
   logic [31:0] frame_limit_ff;

   logic [LW-1:0]    w_eff;
   logic [FCW-1:0]   fw_eff, fh_eff;
   logic [SCW-1:0]   sw_cl, sh_cl, sw_eff, sh_eff;
   logic [2*SCW-1:0] cnt;

   logic    job_push, job_full, job_valid, job_pop;
   job_type job_in, job_out;
   logic [16:0] score;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff   <= 5'd8;
         small_width_ff  <= 7'd32;
         small_height_ff <= 7'd32;
         frame_width_ff  <= 13'd640;
         frame_height_ff <= 13'd480;
         color_mode_ff   <= 1'b1;
         frame_limit_ff  <= '0;
         limit_enable_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            REG_WINDOW_LEN:   window_len_ff   <= csr_wdata[4:0];
            REG_SMALL_WIDTH:  small_width_ff  <= csr_wdata[6:0];
            REG_SMALL_HEIGHT: small_height_ff <= csr_wdata[6:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[12:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata[12:0];
            REG_COLOR_MODE:   color_mode_ff   <= csr_wdata[0];
            REG_FRAME_LIMIT:  frame_limit_ff  <= csr_wdata;
            REG_LIMIT_ENABLE: limit_enable_ff <= csr_wdata[0];
            default:          color_mode_ff   <= color_mode_ff;
         endcase
      end
   end

   always_comb begin
      if (window_len_ff < 5'd2) w_eff = LW'(2);
      else if (32'(window_len_ff) > MAX_WINDOW) w_eff = LW'(MAX_WINDOW);
      else w_eff = LW'(window_len_ff);

      if (frame_width_ff == '0) fw_eff = FCW'(1);
      else if (32'(frame_width_ff) > MAX_FRAME_DIM) fw_eff = FCW'(MAX_FRAME_DIM);
      else fw_eff = FCW'(frame_width_ff);

      if (frame_height_ff == '0) fh_eff = FCW'(1);
      else if (32'(frame_height_ff) > MAX_FRAME_DIM) fh_eff = FCW'(MAX_FRAME_DIM);
      else fh_eff = FCW'(frame_height_ff);

      if (small_width_ff == '0) sw_cl = SCW'(1);
      else if (32'(small_width_ff) > MAX_SMALL_DIM) sw_cl = SCW'(MAX_SMALL_DIM);
      else sw_cl = SCW'(small_width_ff);

      if (small_height_ff == '0) sh_cl = SCW'(1);
      else if (32'(small_height_ff) > MAX_SMALL_DIM) sh_cl = SCW'(MAX_SMALL_DIM);
      else sh_cl = SCW'(small_height_ff);

      sw_eff = (32'(sw_cl) > 32'(fw_eff)) ? SCW'(fw_eff) : sw_cl;
      sh_eff = (32'(sh_cl) > 32'(fh_eff)) ? SCW'(fh_eff) : sh_cl;
   end

   assign cnt = sw_eff * sh_eff;

   tccs_front #(
      .MAX_WINDOW    (MAX_WINDOW),
      .MAX_SMALL_DIM (MAX_SMALL_DIM),
      .MAX_FRAME_DIM (MAX_FRAME_DIM)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_wen),
      .win_len      (w_eff),
      .frm_w        (fw_eff),
      .frm_h        (fh_eff),
      .sml_w        (sw_eff),
      .sml_h        (sh_eff),
      .color_mode   (color_mode_ff),
      .frame_limit  (frame_limit_ff),
      .limit_enable (limit_enable_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .job_push     (job_push),
      .job          (job_in),
      .job_full     (job_full)
   );

   tccs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset || csr_wen),
      .push    (job_push),
      .job_in  (job_in),
      .full    (job_full),
      .pop     (job_pop),
      .job_out (job_out),
      .valid   (job_valid)
   );

   tccs_back #(
      .MAX_WINDOW    (MAX_WINDOW),
      .MAX_SMALL_DIM (MAX_SMALL_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_wen),
      .win_len    (w_eff),
      .cnt        (cnt),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .job        (job_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_score  (score)
   );

   assign rsp_tdata = {7'd0, score};

   `ASSERT_IMPL(a_score_range, rsp_tvalid, rsp_tdata[16:0] <= 17'd65536, "score above one")
   `ASSERT_IMPL(a_no_push_full, job_push, !job_full, "job pushed into full queue")
   `ASSERT_IMPL(a_stall_cause, !req_tready, job_full, "request stalled without full queue")

endmodule

`default_nettype wire
